// File: rtl/assert_macros.svh
// Assertion macros used by the sequencer (cdmd_back) of the motion derivative block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Condition in one cycle implies a condition in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, nxt, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ASSERT_NEXT(label, clk, rst, cond, nxt, msg)
`endif
`endif

// File: rtl/cdmd_pkg.sv
// Shared types and constants of the motion derivative block.
`timescale 1ns / 1ps
`default_nettype none
package cdmd_pkg;

   localparam int MAX_SAMPLES_DEF = 65536;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int QUEUE_DEPTH     = 2;

   typedef struct packed {
      logic [31:0]        sample_time;
      logic signed [31:0] position;
      logic               end_of_series;
   } req_type;

   typedef struct packed {
      logic [15:0]        point_index;
      logic signed [31:0] velocity;
      logic signed [31:0] acceleration;
      logic               last_result;
      logic               zero_interval;
      logic               too_few_samples;
      logic signed [31:0] velocity_max;
      logic signed [31:0] velocity_min;
      logic signed [31:0] velocity_mean;
      logic signed [31:0] accel_max;
      logic signed [31:0] accel_min;
      logic signed [31:0] accel_mean;
   } rsp_type;

   // Status of the shared divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage
`default_nettype wire

// File: rtl/cdmd_front.sv
// Input queue that decouples sample acceptance from the arithmetic sequencer.
`timescale 1ns / 1ps
`default_nettype none
module cdmd_front
   import cdmd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   output logic         full,
   input  wire req_type req_data,
   output logic         q_valid,
   output req_type      q_item,
   input  wire logic    q_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   req_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               wr_en, rd_en;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item  = mem_ff[rd_ptr_ff];
   assign wr_en   = push && !full;
   assign rd_en   = q_pop && q_valid;

   // Pointer and fill-level updates with wrap at the queue depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule
`default_nettype wire

// File: rtl/cdmd_div.sv
// Shared restoring divider, one quotient bit per cycle, saturated Q result.
`timescale 1ns / 1ps
`default_nettype none
module cdmd_div
   import cdmd_pkg::*;
#(
   parameter int NUM_W = 48
)
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic signed [NUM_W-1:0] num,
   input  wire logic signed [32:0]      den,
   output div_stat_type                 stat,
   output logic signed [31:0]           quo,
   output logic                         zero
);

   localparam int CW = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [NUM_W-1:0] nmag_ff, nmag_in;
   logic [32:0]      dmag_ff, dmag_in;
   logic [33:0]      rem_ff, rem_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic             neg_ff, neg_in;
   logic             zero_ff, zero_in;
   logic [33:0]      trial;

   assign trial = {rem_ff[32:0], nmag_ff[NUM_W-1]};

   // Load magnitudes on start, then one shift-subtract step per cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      nmag_in = nmag_ff;
      dmag_in = dmag_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NUM_W);
         nmag_in = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
         dmag_in = den[32] ? 33'(-den) : 33'(den);
         rem_in  = '0;
         q_in    = '0;
         neg_in  = num[NUM_W-1] ^ den[32];
         zero_in = (den == '0);
      end else if (busy_ff) begin
         nmag_in = {nmag_ff[NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, dmag_ff}) begin
            rem_in = trial - {1'b0, dmag_ff};
            q_in   = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      nmag_ff <= nmag_in;
      dmag_ff <= dmag_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   // A zero divisor gives 0; else apply the sign and saturate to the signed 32-bit range.
   always_comb begin
      if (zero_ff) begin
         quo = '0;
      end else if (!neg_ff) begin
         if (q_ff > {{(NUM_W-32){1'b0}}, 32'h7FFF_FFFF}) begin
            quo = 32'sh7FFF_FFFF;
         end else begin
            quo = $signed(q_ff[31:0]);
         end
      end else begin
         if (q_ff > {{(NUM_W-32){1'b0}}, 32'h8000_0000}) begin
            quo = 32'sh8000_0000;
         end else begin
            quo = $signed(-q_ff[31:0]);
         end
      end
   end

   assign zero      = zero_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule
`default_nettype wire

// File: rtl/cdmd_back.sv
// Sequencer that computes derivatives and statistics for queued samples.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cdmd_back
   import cdmd_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_valid,
   input  wire req_type q_item,
   output logic         q_pop,
   output logic         empty,
   input  wire logic    pop,
   output rsp_type      rsp_data
);

   localparam int CNT_W = $clog2(MAX_SAMPLES + 3);
   localparam int CAP   = MAX_SAMPLES + 2;
   localparam int NUM_W = (33 + FRAC_BITS > 48) ? 33 + FRAC_BITS : 48;

   typedef enum logic [3:0] {
      ST_FETCH, ST_VNEW, ST_VN, ST_OLD, ST_EMIT_OLD, ST_A1, ST_EMIT_MID,
      ST_A0, ST_EMIT_NEW, ST_MEAN_V, ST_MEAN_A, ST_FINAL, ST_SHIFT
   } state_type;

   state_type          st_ff, st_in;
   req_type            item_ff, item_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [31:0]        th_ff [3];
   logic [31:0]        th_in [3];
   logic signed [31:0] ph_ff [3];
   logic signed [31:0] ph_in [3];
   logic signed [31:0] vh_ff [3];
   logic signed [31:0] vh_in [3];
   logic               vz_ff [3];
   logic               vz_in [3];
   logic signed [31:0] vm_ff, vm_in, vn_ff, vn_in, aq_ff, aq_in;
   logic               zm_ff, zm_in, zn_ff, zn_in, zq_ff, zq_in;
   logic signed [31:0] mv_ff, mv_in, ma_ff, ma_in;
   logic signed [31:0] vmax_ff, vmax_in, vmin_ff, vmin_in;
   logic signed [31:0] amax_ff, amax_in, amin_ff, amin_in;
   logic signed [47:0] vsum_ff, vsum_in, asum_ff, asum_in;
   logic [15:0]        fidx_ff, fidx_in;
   logic signed [31:0] fv_ff, fv_in, fa_ff, fa_in;
   logic               fz_ff, fz_in, few_ff, few_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               issued_ff, issued_in;

   logic               n1, n2, is_div, div_start, out_free;
   logic signed [32:0] dnum, dden;
   logic signed [NUM_W-1:0] div_num, num_ext;
   logic [CNT_W:0]     pts, dsel;
   div_stat_type       div_stat;
   logic signed [31:0] div_quo;
   logic               div_zero;
   logic               emit_en;
   logic [CNT_W-1:0]   emit_idx;
   logic signed [31:0] emit_v, emit_a;
   logic               emit_z;
   logic signed [48:0] vsum_w, asum_w;

   assign n1       = (cnt_ff == CNT_W'(1));
   assign n2       = (cnt_ff == CNT_W'(2));
   assign out_free = !rsp_valid_ff;
   assign pts      = {1'b0, cnt_ff} + 1'b1;
   assign dsel     = (pts > (CNT_W + 1)'(MAX_SAMPLES)) ? (CNT_W + 1)'(MAX_SAMPLES) : pts;

   // Operand selection for the divider in each division step.
   always_comb begin
      is_div = 1'b1;
      dnum   = '0;
      dden   = '0;
      case (st_ff)
         ST_VNEW: begin
            dnum = 33'(item_ff.position) - 33'(n1 ? ph_ff[0] : ph_ff[1]);
            dden = $signed({1'b0, item_ff.sample_time})
                 - $signed({1'b0, n1 ? th_ff[0] : th_ff[1]});
         end
         ST_VN: begin
            dnum = 33'(item_ff.position) - 33'(ph_ff[0]);
            dden = $signed({1'b0, item_ff.sample_time}) - $signed({1'b0, th_ff[0]});
         end
         ST_OLD: begin
            dnum = 33'(vm_ff) - 33'(n2 ? vh_ff[0] : vh_ff[1]);
            dden = $signed({1'b0, th_ff[0]}) - $signed({1'b0, n2 ? th_ff[1] : th_ff[2]});
         end
         ST_A1: begin
            dnum = 33'(vn_ff) - 33'(vh_ff[0]);
            dden = $signed({1'b0, item_ff.sample_time}) - $signed({1'b0, th_ff[1]});
         end
         ST_A0: begin
            dnum = 33'(vn_ff) - 33'(vm_ff);
            dden = $signed({1'b0, item_ff.sample_time}) - $signed({1'b0, th_ff[0]});
         end
         ST_MEAN_V, ST_MEAN_A: begin
            dden = $signed(33'(dsel));
         end
         default: begin
            is_div = 1'b0;
         end
      endcase
   end

   // Differences are scaled by the fraction bits; the means divide raw sums.
   always_comb begin
      num_ext = NUM_W'(dnum);
      if (st_ff == ST_MEAN_V) begin
         div_num = NUM_W'(vsum_ff);
      end else if (st_ff == ST_MEAN_A) begin
         div_num = NUM_W'(asum_ff);
      end else begin
         div_num = num_ext <<< FRAC_BITS;
      end
   end

   assign div_start = is_div && !issued_ff && !div_stat.busy;

   cdmd_div #(
      .NUM_W(NUM_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num(div_num),
      .den(dden),
      .stat(div_stat),
      .quo(div_quo),
      .zero(div_zero)
   );

   // Fields of the result that the current emit step produces.
   always_comb begin
      emit_en  = 1'b0;
      emit_idx = '0;
      emit_v   = '0;
      emit_a   = '0;
      emit_z   = 1'b0;
      case (st_ff)
         ST_EMIT_OLD: begin
            emit_en  = out_free;
            emit_idx = n1 ? '0 : cnt_ff - CNT_W'(2);
            emit_v   = n1 ? vm_ff : vh_ff[0];
            emit_a   = n1 ? '0 : aq_ff;
            emit_z   = n1 ? zm_ff : (vz_ff[0] || zq_ff);
         end
         ST_EMIT_MID: begin
            emit_en  = out_free;
            emit_idx = cnt_ff - CNT_W'(1);
            emit_v   = vm_ff;
            emit_a   = aq_ff;
            emit_z   = zm_ff || zq_ff;
         end
         ST_EMIT_NEW: begin
            emit_en  = 1'b1;
            emit_idx = n1 ? CNT_W'(1) : cnt_ff;
            emit_v   = n1 ? vm_ff : vn_ff;
            emit_a   = n1 ? '0 : aq_ff;
            emit_z   = n1 ? zm_ff : (zn_ff || zq_ff);
         end
         default: begin
            emit_en = 1'b0;
         end
      endcase
   end

   assign vsum_w = 49'(vsum_ff) + 49'(emit_v);
   assign asum_w = 49'(asum_ff) + 49'(emit_a);

   // Next-state logic of the sequencer and its data registers.
   always_comb begin
      st_in        = st_ff;
      item_in      = item_ff;
      cnt_in       = cnt_ff;
      th_in        = th_ff;
      ph_in        = ph_ff;
      vh_in        = vh_ff;
      vz_in        = vz_ff;
      vm_in        = vm_ff;
      zm_in        = zm_ff;
      vn_in        = vn_ff;
      zn_in        = zn_ff;
      aq_in        = aq_ff;
      zq_in        = zq_ff;
      mv_in        = mv_ff;
      ma_in        = ma_ff;
      vmax_in      = vmax_ff;
      vmin_in      = vmin_ff;
      amax_in      = amax_ff;
      amin_in      = amin_ff;
      vsum_in      = vsum_ff;
      asum_in      = asum_ff;
      fidx_in      = fidx_ff;
      fv_in        = fv_ff;
      fa_in        = fa_ff;
      fz_in        = fz_ff;
      few_in       = few_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !pop;
      issued_in    = issued_ff;
      q_pop        = 1'b0;

      // Divider handshake common to all division steps.
      if (div_start) begin
         issued_in = 1'b1;
      end

      // Statistics update for every emitted point.
      if (emit_en) begin
         if (emit_idx == '0) begin
            vmax_in = emit_v;
            vmin_in = emit_v;
            amax_in = emit_a;
            amin_in = emit_a;
         end else begin
            if (emit_v > vmax_ff) vmax_in = emit_v;
            if (emit_v < vmin_ff) vmin_in = emit_v;
            if (emit_a > amax_ff) amax_in = emit_a;
            if (emit_a < amin_ff) amin_in = emit_a;
         end
         if (vsum_w > 49'sh0_7FFF_FFFF_FFFF) begin
            vsum_in = 48'sh7FFF_FFFF_FFFF;
         end else if (vsum_w < -49'sh0_8000_0000_0000) begin
            vsum_in = 48'sh8000_0000_0000;
         end else begin
            vsum_in = vsum_w[47:0];
         end
         if (asum_w > 49'sh0_7FFF_FFFF_FFFF) begin
            asum_in = 48'sh7FFF_FFFF_FFFF;
         end else if (asum_w < -49'sh0_8000_0000_0000) begin
            asum_in = 48'sh8000_0000_0000;
         end else begin
            asum_in = asum_w[47:0];
         end
         if (st_ff != ST_EMIT_NEW) begin
            rsp_in               = '0;
            rsp_in.point_index   = 16'(emit_idx);
            rsp_in.velocity      = emit_v;
            rsp_in.acceleration  = emit_a;
            rsp_in.zero_interval = emit_z;
            rsp_valid_in         = 1'b1;
         end
      end

      case (st_ff)
         ST_FETCH: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               item_in = q_item;
               if (q_item.end_of_series && cnt_ff == '0) begin
                  fidx_in = '0;
                  fv_in   = '0;
                  fa_in   = '0;
                  fz_in   = 1'b0;
                  few_in  = 1'b1;
                  mv_in   = '0;
                  ma_in   = '0;
                  st_in   = ST_FINAL;
               end else if (cnt_ff == '0) begin
                  st_in = ST_SHIFT;
               end else begin
                  st_in = ST_VNEW;
               end
            end
         end
         ST_VNEW: begin
            if (div_stat.done) begin
               issued_in = 1'b0;
               vm_in     = div_quo;
               zm_in     = div_zero;
               if (item_ff.end_of_series) begin
                  st_in = n1 ? ST_EMIT_OLD : ST_VN;
               end else begin
                  st_in = n1 ? ST_SHIFT : ST_OLD;
               end
            end
         end
         ST_VN: begin
            if (div_stat.done) begin
               issued_in = 1'b0;
               vn_in     = div_quo;
               zn_in     = div_zero;
               st_in     = ST_OLD;
            end
         end
         ST_OLD, ST_A1, ST_A0: begin
            if (div_stat.done) begin
               issued_in = 1'b0;
               aq_in     = div_quo;
               zq_in     = div_zero;
               case (st_ff)
                  ST_OLD:  st_in = ST_EMIT_OLD;
                  ST_A1:   st_in = ST_EMIT_MID;
                  default: st_in = ST_EMIT_NEW;
               endcase
            end
         end
         ST_EMIT_OLD: begin
            if (out_free) begin
               if (!item_ff.end_of_series) begin
                  st_in = ST_SHIFT;
               end else if (n1) begin
                  st_in = ST_EMIT_NEW;
               end else begin
                  st_in = ST_A1;
               end
            end
         end
         ST_EMIT_MID: begin
            if (out_free) begin
               st_in = ST_A0;
            end
         end
         ST_EMIT_NEW: begin
            fidx_in = 16'(emit_idx);
            fv_in   = emit_v;
            fa_in   = emit_a;
            fz_in   = emit_z;
            few_in  = 1'b0;
            st_in   = ST_MEAN_V;
         end
         ST_MEAN_V: begin
            if (div_stat.done) begin
               issued_in = 1'b0;
               mv_in     = div_quo;
               st_in     = ST_MEAN_A;
            end
         end
         ST_MEAN_A: begin
            if (div_stat.done) begin
               issued_in = 1'b0;
               ma_in     = div_quo;
               st_in     = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               rsp_in.point_index     = fidx_ff;
               rsp_in.velocity        = fv_ff;
               rsp_in.acceleration    = fa_ff;
               rsp_in.last_result     = 1'b1;
               rsp_in.zero_interval   = fz_ff;
               rsp_in.too_few_samples = few_ff;
               rsp_in.velocity_max    = vmax_ff;
               rsp_in.velocity_min    = vmin_ff;
               rsp_in.velocity_mean   = mv_ff;
               rsp_in.accel_max       = amax_ff;
               rsp_in.accel_min       = amin_ff;
               rsp_in.accel_mean      = ma_ff;
               rsp_valid_in           = 1'b1;
               // The series is done: start the next one from a clean state.
               cnt_in  = '0;
               vmax_in = '0;
               vmin_in = '0;
               amax_in = '0;
               amin_in = '0;
               vsum_in = '0;
               asum_in = '0;
               for (int i = 0; i < 3; i++) begin
                  th_in[i] = '0;
                  ph_in[i] = '0;
                  vh_in[i] = '0;
                  vz_in[i] = 1'b0;
               end
               st_in = ST_FETCH;
            end
         end
         ST_SHIFT: begin
            th_in[2] = th_ff[1];
            th_in[1] = th_ff[0];
            th_in[0] = item_ff.sample_time;
            ph_in[2] = ph_ff[1];
            ph_in[1] = ph_ff[0];
            ph_in[0] = item_ff.position;
            if (cnt_ff != '0) begin
               vh_in[2] = vh_ff[1];
               vh_in[1] = vh_ff[0];
               vh_in[0] = vm_ff;
               vz_in[2] = vz_ff[1];
               vz_in[1] = vz_ff[0];
               vz_in[0] = zm_ff;
            end
            cnt_in = (cnt_ff == CNT_W'(CAP)) ? CNT_W'(CAP) : cnt_ff + 1'b1;
            st_in  = ST_FETCH;
         end
         default: begin
            st_in = ST_FETCH;
         end
      endcase
   end

   // State, series history and registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_FETCH;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         issued_ff    <= 1'b0;
         vmax_ff      <= '0;
         vmin_ff      <= '0;
         amax_ff      <= '0;
         amin_ff      <= '0;
         vsum_ff      <= '0;
         asum_ff      <= '0;
         for (int i = 0; i < 3; i++) begin
            th_ff[i] <= '0;
            ph_ff[i] <= '0;
            vh_ff[i] <= '0;
            vz_ff[i] <= 1'b0;
         end
      end else begin
         st_ff        <= st_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         issued_ff    <= issued_in;
         vmax_ff      <= vmax_in;
         vmin_ff      <= vmin_in;
         amax_ff      <= amax_in;
         amin_ff      <= amin_in;
         vsum_ff      <= vsum_in;
         asum_ff      <= asum_in;
         th_ff        <= th_in;
         ph_ff        <= ph_in;
         vh_ff        <= vh_in;
         vz_ff        <= vz_in;
      end
      item_ff <= item_in;
      vm_ff   <= vm_in;
      zm_ff   <= zm_in;
      vn_ff   <= vn_in;
      zn_ff   <= zn_in;
      aq_ff   <= aq_in;
      zq_ff   <= zq_in;
      mv_ff   <= mv_in;
      ma_ff   <= ma_in;
      fidx_ff <= fidx_in;
      fv_ff   <= fv_in;
      fa_ff   <= fa_in;
      fz_ff   <= fz_in;
      few_ff  <= few_in;
      rsp_ff  <= rsp_in;
   end

   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

   `ASSERT_ALWAYS(a_start_idle, clock, reset, !div_start || !div_stat.busy, "divider restarted while busy")
   `ASSERT_ALWAYS(a_cnt_cap, clock, reset, cnt_ff <= CNT_W'(CAP), "sample count above its cap")
   `ASSERT_NEXT(a_final_clears, clock, reset, st_ff == ST_FINAL && out_free, cnt_ff == '0 && rsp_ff.last_result, "final result did not clear the series")
   `ASSERT_ALWAYS(a_no_overwrite, clock, reset, !(emit_en && st_ff != ST_EMIT_NEW) || !rsp_valid_ff, "result register overwritten")

endmodule
`default_nettype wire

// File: rtl/central_difference_motion_derivatives.sv
// Top level of the streaming central difference motion derivative block.
//
// Channel   Direction  Handshake               Payload
// request   in         push / full             req_data  (req_type)
// response  out        pop / empty             rsp_data  (rsp_type)
//
// Samples enter a two-entry queue and are worked off one at a time by a
// sequencer around one shared restoring divider that produces one quotient
// bit per cycle (49 bits at the default fraction width). A sample takes 0
// to 5 divisions, plus 2 for the means on the last sample of a series of two
// or more samples; from the third sample on, a non-final sample takes 2.
// Reset is synchronous and clears the queue, the series state and the result.
// A result that waits to be popped stalls the sequencer; the queue keeps
// taking samples until it is full.
`timescale 1ns / 1ps
`default_nettype none
module central_difference_motion_derivatives
   import cdmd_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   output logic         full,
   input  wire req_type req_data,
   output logic         empty,
   input  wire logic    pop,
   output rsp_type      rsp_data
);

   logic    q_valid;
   logic    q_pop;
   req_type q_item;

   // Front: sample queue.
   cdmd_front u_front (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_data(req_data),
      .q_valid(q_valid),
      .q_item(q_item),
      .q_pop(q_pop)
   );

   // Back: derivative sequencer with the result register.
   cdmd_back #(
      .MAX_SAMPLES(MAX_SAMPLES),
      .FRAC_BITS(FRAC_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_item(q_item),
      .q_pop(q_pop),
      .empty(empty),
      .pop(pop),
      .rsp_data(rsp_data)
   );

endmodule
`default_nettype wire

// File: dv/central_difference_motion_derivatives_test.sv
// Self-checking testbench for the central difference motion derivative block.
`timescale 1ns / 1ps
`default_nettype none
module central_difference_motion_derivatives_test;
   import cdmd_pkg::*;

   localparam int        MAX_PTS     = MAX_SAMPLES_DEF;
   localparam int        FRAC        = FRAC_BITS_DEF;
   localparam longint    SUM_MAX     = (64'sd1 <<< 47) - 1;
   localparam longint    SUM_MIN     = -(64'sd1 <<< 47);
   localparam int        STALL_LIMIT = 20000;
   localparam int        DRAIN_WAIT  = 800;
   localparam int        ONE_SEC     = 1 << FRAC;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    full;
   req_type req_data = '0;
   logic    empty;
   logic    pop = 1'b0;
   rsp_type rsp_data;

   // Shared control between the stimulus and the response side.
   bit      steady = 1'b0;
   int      pop_hold = 0;
   int      mismatches = 0;
   int      idle_cycles = 0;
   rsp_type expected_rsp[$];

   // Derivative engine state, mirrored from the block's behavior.
   longint  time_hist[3];
   int      pos_hist[3];
   int      vel_hist[3];
   bit      vel_zero[3];
   int unsigned samples_seen;
   int      vel_max, vel_min, acc_max, acc_min;
   longint  vel_sum, acc_sum;

   central_difference_motion_derivatives u_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always #6 clock = ~clock;

   // Clear the series state, as the block does after every final result.
   function automatic void clear_series();
      for (int i = 0; i < 3; i++) begin
         time_hist[i] = 0;
         pos_hist[i] = 0;
         vel_hist[i] = 0;
         vel_zero[i] = 1'b0;
      end
      samples_seen = 0;
      vel_max = 0;
      vel_min = 0;
      acc_max = 0;
      acc_min = 0;
      vel_sum = 0;
      acc_sum = 0;
   endfunction

   function automatic int sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
   endfunction

   function automatic longint sat48(longint v);
      if (v > SUM_MAX) return SUM_MAX;
      if (v < SUM_MIN) return SUM_MIN;
      return v;
   endfunction

   // Fixed point quotient; a zero divisor gives 0 and raises the flag.
   function automatic int fixed_quotient(longint num, longint den, ref bit zero);
      if (den == 0) begin
         zero = 1'b1;
         return 0;
      end
      return sat32((num <<< FRAC) / den);
   endfunction

   // Acceleration of the point two samples back, given the newest velocity.
   function automatic int lagged_accel(int unsigned n, int vnew, ref bit zero);
      if (n == 2)
         return fixed_quotient(longint'(vnew) - vel_hist[0], time_hist[0] - time_hist[1], zero);
      return fixed_quotient(longint'(vnew) - vel_hist[1], time_hist[0] - time_hist[2], zero);
   endfunction

   // Queue one point result and fold it into the series statistics.
   function automatic void add_point(int unsigned idx, int v, int a, bit z);
      rsp_type r;
      r = '0;
      r.point_index = idx[15:0];
      r.velocity = v;
      r.acceleration = a;
      r.zero_interval = z;
      expected_rsp = {expected_rsp, r};
      if (idx == 0) begin
         vel_max = v;
         vel_min = v;
         acc_max = a;
         acc_min = a;
      end else begin
         if (v > vel_max) vel_max = v;
         if (v < vel_min) vel_min = v;
         if (a > acc_max) acc_max = a;
         if (a < acc_min) acc_min = a;
      end
      vel_sum = sat48(vel_sum + v);
      acc_sum = sat48(acc_sum + a);
   endfunction

   // Mark the newest result as the last of the series and attach statistics.
   function automatic void close_series(int unsigned points);
      rsp_type r;
      longint d;
      r = expected_rsp.pop_back();
      d = (points > MAX_PTS) ? MAX_PTS : points;
      if (d < 1) d = 1;
      r.last_result = 1'b1;
      r.velocity_max = vel_max;
      r.velocity_min = vel_min;
      r.velocity_mean = sat32(vel_sum / d);
      r.accel_max = acc_max;
      r.accel_min = acc_min;
      r.accel_mean = sat32(acc_sum / d);
      expected_rsp = {expected_rsp, r};
   endfunction

   // Work out the results that one accepted sample causes.
   function automatic void predict_derivatives(req_type s);
      longint t, x;
      int unsigned n;
      bit zv, za, zm, zn, zb, zc;
      int v, a, vm, vn, a0, a1, a2;
      t = longint'({32'd0, s.sample_time});
      x = longint'(s.position);
      n = samples_seen;
      zv = 0; za = 0; zm = 0; zn = 0; zb = 0; zc = 0;
      if (s.end_of_series) begin
         if (n == 0) begin
            rsp_type r;
            r = '0;
            r.last_result = 1'b1;
            r.too_few_samples = 1'b1;
            expected_rsp = {expected_rsp, r};
         end else begin
            if (n == 1) begin
               v = fixed_quotient(x - pos_hist[0], t - time_hist[0], zv);
               a = fixed_quotient(0, t - time_hist[0], zv);
               add_point(0, v, a, zv);
               add_point(1, v, a, zv);
            end else begin
               vm = fixed_quotient(x - pos_hist[1], t - time_hist[1], zm);
               vn = fixed_quotient(x - pos_hist[0], t - time_hist[0], zn);
               a2 = lagged_accel(n, vm, za);
               a1 = fixed_quotient(longint'(vn) - vel_hist[0], t - time_hist[1], zb);
               a0 = fixed_quotient(longint'(vn) - vm, t - time_hist[0], zc);
               add_point(n - 2, vel_hist[0], a2, vel_zero[0] | za);
               add_point(n - 1, vm, a1, zm | zb);
               add_point(n, vn, a0, zn | zc);
            end
            close_series(n + 1);
         end
         clear_series();
         return;
      end
      if (n >= 1) begin
         if (n == 1) v = fixed_quotient(x - pos_hist[0], t - time_hist[0], zv);
         else v = fixed_quotient(x - pos_hist[1], t - time_hist[1], zv);
         if (n >= 2) begin
            a = lagged_accel(n, v, za);
            add_point(n - 2, vel_hist[0], a, vel_zero[0] | za);
         end
         vel_hist[2] = vel_hist[1];
         vel_zero[2] = vel_zero[1];
         vel_hist[1] = vel_hist[0];
         vel_zero[1] = vel_zero[0];
         vel_hist[0] = v;
         vel_zero[0] = zv;
      end
      time_hist[2] = time_hist[1];
      time_hist[1] = time_hist[0];
      time_hist[0] = t;
      pos_hist[2] = pos_hist[1];
      pos_hist[1] = pos_hist[0];
      pos_hist[0] = int'(x);
      samples_seen = (n + 1 > MAX_PTS + 2) ? MAX_PTS + 2 : n + 1;
   endfunction

   // Offer one sample, with a random gap first, and wait until it is taken.
   task automatic send_sample(logic [31:0] t, logic signed [31:0] x, bit last);
      req_type s;
      int gap;
      s.sample_time = t;
      s.position = x;
      s.end_of_series = last;
      gap = (!steady && $urandom_range(99) < 28) ? $urandom_range(1, 5) : 0;
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_data <= s;
      do @(posedge clock); while (full);
      predict_derivatives(s);
   endtask

   // Compare one field and report the first few differences.
   task automatic check_field(string name, longint exp_v, longint got_v);
      if (exp_v != got_v) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%t %s: expected %0d, got %0d", $realtime, name, exp_v, got_v);
      end
   endtask

   // Check every popped transaction against the oldest expectation.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && pop && !empty) begin
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%t unexpected result transaction, index %0d",
                        $realtime, rsp_data.point_index);
         end else begin
            e = expected_rsp.pop_front();
            check_field("point_index", e.point_index, rsp_data.point_index);
            check_field("velocity", e.velocity, rsp_data.velocity);
            check_field("acceleration", e.acceleration, rsp_data.acceleration);
            check_field("last_result", e.last_result, rsp_data.last_result);
            check_field("zero_interval", e.zero_interval, rsp_data.zero_interval);
            check_field("too_few_samples", e.too_few_samples, rsp_data.too_few_samples);
            check_field("velocity_max", e.velocity_max, rsp_data.velocity_max);
            check_field("velocity_min", e.velocity_min, rsp_data.velocity_min);
            check_field("velocity_mean", e.velocity_mean, rsp_data.velocity_mean);
            check_field("accel_max", e.accel_max, rsp_data.accel_max);
            check_field("accel_min", e.accel_min, rsp_data.accel_min);
            check_field("accel_mean", e.accel_mean, rsp_data.accel_mean);
         end
      end
      // Pick the next pop: a long hold, steady draining or random stalls.
      if (reset || pop_hold > 0) begin
         pop <= 1'b0;
         if (pop_hold > 0) pop_hold <= pop_hold - 1;
      end else begin
         pop <= steady || ($urandom_range(99) >= 28);
      end
   end

   // Watchdog on cycles in which no transaction moves on either side.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Two series that each end on their first sample.
   task automatic test_single_sample();
      send_sample(32'h0001_0000, 32'sh0000_1234, 1'b1);
      send_sample(32'hffff_ffff, 32'sh8000_0000, 1'b1);
   endtask

   // Two series of two samples: one-sided differences, including a zero interval.
   task automatic test_two_samples();
      send_sample(32'h0000_0000, 32'sh0001_0000, 1'b0);
      send_sample(32'h0002_0000, 32'sh0005_0000, 1'b1);
      send_sample(32'h0003_0000, 32'sh0001_0000, 1'b0);
      send_sample(32'h0003_0000, 32'sh0007_0000, 1'b1);
   endtask

   // Repeated times inside a longer series flag zero divisors.
   task automatic test_zero_interval();
      send_sample(32'h0000_0000, 32'sh0000_0000, 1'b0);
      send_sample(32'h0001_0000, 32'sh0001_0000, 1'b0);
      send_sample(32'h0001_0000, 32'sh0002_0000, 1'b0);
      send_sample(32'h0002_0000, 32'sh0003_0000, 1'b0);
      send_sample(32'h0002_0000, 32'sh0004_0000, 1'b1);
   endtask

   // Extreme times and positions saturate velocity and acceleration.
   task automatic test_extremes();
      send_sample(32'h0000_0000, 32'sh8000_0000, 1'b0);
      send_sample(32'h0000_0001, 32'sh7fff_ffff, 1'b0);
      send_sample(32'h0000_0002, 32'sh8000_0000, 1'b0);
      send_sample(32'hffff_ffff, 32'sh7fff_ffff, 1'b0);
      send_sample(32'hffff_fffe, 32'sh0000_0000, 1'b1);
   endtask

   // Decreasing time gives signed differences.
   task automatic test_reversed_time();
      send_sample(32'h0010_0000, 32'sh0000_0000, 1'b0);
      send_sample(32'h000f_8000, 32'sh0000_4000, 1'b0);
      send_sample(32'h000e_0000, -32'sh0003_0000, 1'b0);
      send_sample(32'h000d_0000, 32'sh0002_0000, 1'b1);
   endtask

   // Random series, mostly smooth motion with occasional wild samples.
   task automatic run_series(int count);
      logic [31:0] t;
      logic signed [31:0] x;
      int len;
      int sel;
      t = $urandom;
      x = $urandom;
      len = $urandom_range(1, 12);
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(99);
         if (sel < 8) t = $urandom;
         else if (sel >= 16) t = t + $urandom_range(1, 4 * ONE_SEC);
         if ($urandom_range(99) < 12) x = $urandom;
         else x = x + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
         len--;
         send_sample(t, x, len == 0 || i == count - 1);
         if (len == 0) len = $urandom_range(1, 12);
      end
   endtask

   task automatic test_random_series();
      steady = 1'b1;
      run_series(40);
      steady = 1'b0;
      run_series(110);
   endtask

   // Hold the response side off while samples keep arriving.
   task automatic test_backpressure();
      pop_hold = 1500;
      run_series(12);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      clear_series();
      @(posedge clock);
      test_single_sample();
      test_two_samples();
      test_zero_interval();
      test_extremes();
      test_reversed_time();
      test_random_series();
      test_backpressure();
      push <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire
